// ===== hw/rtl/pdtt_pkg.sv =====
`timescale 1ns / 1ps
package pdtt_pkg;

    localparam logic [2:0] ST_MATCH  = 3'd0;
    localparam logic [2:0] ST_RELINK = 3'd1;
    localparam logic [2:0] ST_NEW    = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;

    localparam logic [11:0] RELINK_RESET = 12'd64;
    localparam logic [0:0]  REG_RELINK   = 1'b0;

    typedef struct packed {
        logic        command;
        logic [47:0] source_address;
        logic [31:0] chip_fingerprint;
        logic [11:0] sequence_number;
        logic signed [7:0] signal_strength;
        logic [5:0]  name_length;
        logic [31:0] arrival_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  device_slot;
        logic [15:0] device_probes;
        logic [7:0]  device_identities;
        logic signed [7:0] device_best_signal;
        logic [7:0]  device_wildcards;
        logic [31:0] total_probes;
        logic [31:0] total_wildcards;
    } t_out_item;

    typedef struct packed {
        logic [47:0] address;
        logic [31:0] fingerprint;
        logic [11:0] last_sequence;
        logic [31:0] last_time;
        logic [15:0] probe_count;
        logic [7:0]  identity_count;
        logic signed [7:0] best_signal;
        logic [7:0]  wildcard_count;
    } t_entry;

    // Control from the sequencer to each cell; load, relink and fresh reach only the addressed cell.
    typedef struct packed {
        logic        shift;
        logic        load;
        logic        relink;
        logic        fresh;
        logic [47:0] address;
        logic [31:0] fingerprint;
        logic [11:0] sequence_number;
        logic signed [7:0] signal_strength;
        logic        wild;
        logic [31:0] arrival_time;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/pdtt_cell.sv =====
`timescale 1ns / 1ps
module pdtt_cell (
    input  logic                i_clk,
    input  pdtt_pkg::t_cell_ctl i_ctl,
    input  pdtt_pkg::t_entry    i_prev,
    output pdtt_pkg::t_entry    o_entry
);
    import pdtt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    t_entry w_base;

    always_comb begin
        w_base  = r_entry;
        n_entry = r_entry;
        if (i_ctl.fresh) begin
            w_base.address        = i_ctl.address;
            w_base.fingerprint    = i_ctl.fingerprint;
            w_base.identity_count = 8'd1;
            w_base.best_signal    = -8'sd128;
            w_base.probe_count    = 16'd0;
            w_base.wildcard_count = 8'd0;
        end else if (i_ctl.relink) begin
            w_base.address = i_ctl.address;
            if (r_entry.identity_count != 8'hFF) begin
                w_base.identity_count = r_entry.identity_count + 8'd1;
            end
        end
        if (i_ctl.load) begin
            n_entry = w_base;
            if (w_base.probe_count != 16'hFFFF) begin
                n_entry.probe_count = w_base.probe_count + 16'd1;
            end
            n_entry.last_sequence = i_ctl.sequence_number;
            n_entry.last_time     = i_ctl.arrival_time;
            if (i_ctl.signal_strength > w_base.best_signal) begin
                n_entry.best_signal = i_ctl.signal_strength;
            end
            if (i_ctl.wild && w_base.wildcard_count != 8'hFF) begin
                n_entry.wildcard_count = w_base.wildcard_count + 8'd1;
            end
        end else if (i_ctl.shift) begin
            n_entry = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule

// ===== hw/rtl/probe_device_tracking_table_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Payload
// command  | in        | i_start / o_busy     | i_item (t_in_item)
// result   | out       | o_done strobe        | o_result (t_out_item)
// config   | in        | APB psel/penable     | relink_window at 0x0
// The table is a ring of DEVICE_SLOTS cells that rotates one place a cycle while it searches.
// An observe holds o_busy through one rotation for the address search, one rotation for
// the fingerprint search, an update state and a result state; the
// fingerprint rotation is skipped on an address match or a zero fingerprint.
// o_done shows the result in the cycle in which o_busy falls; a clear answers in the next
// cycle. Reset clears the fill count and the totals. The receiver cannot stall.
module probe_device_tracking_table_unit #(
    parameter int DEVICE_SLOTS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  pdtt_pkg::t_in_item  i_item,
    output logic                o_done,
    output pdtt_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [0:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pdtt_pkg::*;

    localparam int IW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
    localparam int CW = $clog2(DEVICE_SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADDR = 5'b00010,
        S_FP   = 5'b00100,
        S_UPD  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    logic [11:0]  r_window, n_window;
    logic [CW-1:0] r_used, n_used;
    logic [31:0]  r_probes, n_probes;
    logic [31:0]  r_wilds, n_wilds;
    t_in_item     r_item, n_item;
    logic [IW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_slot, n_slot;
    logic         r_found, n_found;
    logic [2:0]   r_status, n_status;
    t_out_item    r_result, n_result;
    logic         r_done, n_done;

    t_cell_ctl    w_ctl [DEVICE_SLOTS];
    t_entry       w_ent [DEVICE_SLOTS];
    t_entry       w_head;
    logic [11:0]  w_dist;
    logic         w_head_valid;
    logic         w_addr_hit, w_fp_hit, w_hit;
    logic         w_wild;
    logic         w_last;

    assign pready = 1'b1;
    assign prdata = {20'd0, r_window};
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_result = r_result;

    // Cell 0 is the head; at step k it holds logical entry r_pos.
    assign w_head = w_ent[0];
    assign w_head_valid = (CW'(r_pos) < r_used);
    assign w_dist = r_item.sequence_number - w_head.last_sequence;
    assign w_addr_hit = w_head_valid && (w_head.address == r_item.source_address);
    assign w_fp_hit = w_head_valid && (r_item.chip_fingerprint != 32'd0)
                   && (w_head.fingerprint == r_item.chip_fingerprint)
                   && (w_dist != 12'd0) && (w_dist <= r_window);
    assign w_hit = (r_state == S_ADDR) ? w_addr_hit : w_fp_hit;
    assign w_wild = (r_item.name_length == 6'd0);
    assign w_last = (r_pos == IW'(DEVICE_SLOTS - 1));

    genvar g;
    generate
        for (g = 0; g < DEVICE_SLOTS; g++) begin : g_cell
            always_comb begin
                w_ctl[g] = '0;
                w_ctl[g].shift = (r_state == S_ADDR) || (r_state == S_FP);
                w_ctl[g].address = r_item.source_address;
                w_ctl[g].fingerprint = r_item.chip_fingerprint;
                w_ctl[g].sequence_number = r_item.sequence_number;
                w_ctl[g].signal_strength = r_item.signal_strength;
                w_ctl[g].wild = w_wild;
                w_ctl[g].arrival_time = r_item.arrival_time;
                if (r_state == S_UPD && r_status != ST_FULL && r_slot == IW'(g)) begin
                    w_ctl[g].load = 1'b1;
                    w_ctl[g].relink = (r_status == ST_RELINK);
                    w_ctl[g].fresh = (r_status == ST_NEW);
                end
            end
            pdtt_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl[g]),
                .i_prev (w_ent[(g + 1) % DEVICE_SLOTS]),
                .o_entry(w_ent[g])
            );
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_window = r_window;
        n_used   = r_used;
        n_probes = r_probes;
        n_wilds  = r_wilds;
        n_item   = r_item;
        n_pos    = r_pos;
        n_slot   = r_slot;
        n_found  = r_found;
        n_status = r_status;
        n_result = r_result;
        n_done   = 1'b0;
        if (psel && penable && pwrite && paddr == REG_RELINK) begin
            n_window = pwdata[11:0];
        end
        unique case (r_state) inside
            S_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_pos   = '0;
                    n_found = 1'b0;
                    n_slot  = '0;
                    if (i_item.command) begin
                        n_used          = '0;
                        n_probes        = '0;
                        n_wilds         = '0;
                        n_result        = '0;
                        n_result.status = ST_CLEAR;
                        n_done          = 1'b1;
                    end else begin
                        n_state = S_ADDR;
                        if (r_probes != 32'hFFFF_FFFF) n_probes = r_probes + 32'd1;
                        if (i_item.name_length == 6'd0 && r_wilds != 32'hFFFF_FFFF)
                            n_wilds = r_wilds + 32'd1;
                    end
                end
            end
            S_ADDR, S_FP: begin
                n_pos = w_last ? '0 : r_pos + IW'(1);
                if (!r_found && w_hit) begin
                    n_found  = 1'b1;
                    n_slot   = r_pos;
                    n_status = (r_state == S_ADDR) ? ST_MATCH : ST_RELINK;
                end
                if (w_last) begin
                    if (r_found || w_hit) begin
                        n_state = S_UPD;
                    end else if (r_state == S_ADDR && r_item.chip_fingerprint != 32'd0) begin
                        n_state = S_FP;
                    end else begin
                        n_state  = S_UPD;
                        n_slot   = IW'(r_used);
                        n_status = (r_used == CW'(DEVICE_SLOTS)) ? ST_FULL : ST_NEW;
                    end
                end
            end
            S_UPD: begin
                n_state = S_OUT;
                if (r_status == ST_NEW) n_used = r_used + CW'(1);
            end
            S_OUT: begin
                n_state                  = S_IDLE;
                n_done                   = 1'b1;
                n_result                 = '0;
                n_result.status          = r_status;
                n_result.total_probes    = r_probes;
                n_result.total_wildcards = r_wilds;
                if (r_status != ST_FULL) begin
                    n_result.device_slot        = 5'(r_slot);
                    n_result.device_probes      = w_ent[r_slot].probe_count;
                    n_result.device_identities  = w_ent[r_slot].identity_count;
                    n_result.device_best_signal = w_ent[r_slot].best_signal;
                    n_result.device_wildcards   = w_ent[r_slot].wildcard_count;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_window <= RELINK_RESET;
            r_used   <= '0;
            r_probes <= '0;
            r_wilds  <= '0;
            r_item   <= '0;
            r_pos    <= '0;
            r_slot   <= '0;
            r_found  <= 1'b0;
            r_status <= ST_MATCH;
            r_result <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_window <= n_window;
            r_used   <= n_used;
            r_probes <= n_probes;
            r_wilds  <= n_wilds;
            r_item   <= n_item;
            r_pos    <= n_pos;
            r_slot   <= n_slot;
            r_found  <= n_found;
            r_status <= n_status;
            r_result <= n_result;
            r_done   <= n_done;
        end
    end

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(DEVICE_SLOTS)) else $error("fill count overflow");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("result while busy");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> o_done) else $error("missing result");
    a_busy_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_item.command) |=> o_busy) else $error("start lost");
`endif
endmodule
